[hw/rtl/crkt_pkg.sv]
// shared types and constants for the connection retry and keepalive timer
// no dependencies; imported by every module of the block but crkt_ram
package crkt_pkg;

    // table geometry and field widths
    localparam int SLOTS_DEF   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int SLOT_W      = 5;
    localparam int CLASS_W     = 2;
    localparam int IVL_W       = 16;
    localparam int ATT_W       = 8;
    localparam int VERDICT_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PINGS_BEFORE_PURGE = 2'd1;

    // configuration reset values
    localparam logic [IVL_W-1:0] TBP_RESET = 16'd10;
    localparam logic [ATT_W-1:0] PBP_RESET = 8'd3;

    // connection classes
    localparam logic [CLASS_W-1:0] CLS_AWAIT = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_TIMED = 2'd2;

    // saturation value of a doubled interval
    localparam logic [IVL_W-1:0] IVL_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SETC   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACK   = 3'd0,
        V_RETRY = 3'd1,
        V_TIMED = 3'd2,
        V_PING  = 3'd3,
        V_PURGE = 3'd4
    } verdict_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t                kind;
        logic               in_range;
        logic [SLOT_W-1:0]  slot;
        logic [CLASS_W-1:0] conn_class;
        logic [IVL_W-1:0]   retry_interval;
        logic [ATT_W-1:0]   attempts;
    } cmd_t;

    // one slot of the table as stored in memory
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [IVL_W-1:0]   period;
        logic [IVL_W-1:0]   retry_cd;
        logic [ATT_W-1:0]   att_left;
        logic [IVL_W-1:0]   ping_cd;
        logic [ATT_W-1:0]   pings_left;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        entry_t   entry;
        verdict_t verdict;
    } step_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETC,
        B_ACK,
        B_TICK,
        B_FLUSH
    } back_state_t;

endpackage

[hw/rtl/crkt_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module crkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/crkt_queue.sv]
// short command queue between the front and back parts
// depends on crkt_pkg for cmd_t
module crkt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crkt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output crkt_pkg::cmd_t head
);
    import crkt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             buf_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = buf_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/crkt_front.sv]
// front part: accepts input transfers, decodes and range-checks them
// depends on crkt_pkg and crkt_queue
module crkt_front #(
    parameter int SLOTS = crkt_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [crkt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [crkt_pkg::IN_USER_W-1:0] s_axis_tuser,
    input  logic                           pop,
    output logic                           cmd_valid,
    output crkt_pkg::cmd_t                 cmd
);
    import crkt_pkg::*;

    logic full;
    logic push;
    cmd_t dec;

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && s_axis_tready;

    // field unpacking and classification
    always_comb
    begin
        dec.slot           = s_axis_tdata[4:0];
        dec.conn_class     = s_axis_tdata[6:5];
        dec.retry_interval = s_axis_tdata[22:7];
        dec.attempts       = s_axis_tdata[30:23];
        dec.in_range       = ((SLOT_W + 2)'(dec.slot) < (SLOT_W + 2)'(SLOTS));
        unique case (s_axis_tuser)
            2'd0:    dec.kind = OP_TICK;
            2'd1:    dec.kind = OP_LOAD;
            2'd2:    dec.kind = OP_SETC;
            default: dec.kind = OP_REMOVE;
        endcase
    end

    crkt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (dec),
        .full      (full),
        .pop       (pop),
        .not_empty (cmd_valid),
        .head      (cmd)
    );

endmodule

[hw/rtl/crkt_back.sv]
// back part: slot table, tick walk, configuration registers and output register
// depends on crkt_pkg and crkt_ram
module crkt_back #(
    parameter int SLOTS = crkt_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  crkt_pkg::cmd_t                  cmd,
    output logic                            pop,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crkt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crkt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [crkt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import crkt_pkg::*;

    localparam int IDXW  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // advance one valid slot by one tick
    function automatic step_t slot_step(entry_t e, logic [IVL_W-1:0] tbp);
        step_t            s;
        logic [IVL_W:0]   dbl;
        s.entry   = e;
        s.verdict = V_ACK;
        dbl       = {e.period, 1'b0};
        if (e.cls == CLS_TIMED)
        begin
            s.verdict = V_PURGE;
        end
        else if (e.cls == CLS_AWAIT)
        begin
            if (e.retry_cd != '0)
            begin
                s.entry.retry_cd = e.retry_cd - 1'b1;
            end
            if (s.entry.retry_cd == '0)
            begin
                if (e.att_left != '0)
                begin
                    s.entry.att_left = e.att_left - 1'b1;
                end
                if (s.entry.att_left == '0)
                begin
                    s.verdict = V_TIMED;
                end
                else
                begin
                    s.entry.period   = dbl[IVL_W] ? IVL_MAX : dbl[IVL_W-1:0];
                    s.entry.retry_cd = s.entry.period;
                    s.verdict        = V_RETRY;
                end
            end
        end
        else
        begin
            if (e.ping_cd != '0)
            begin
                s.entry.ping_cd = e.ping_cd - 1'b1;
            end
            if (s.entry.ping_cd == '0)
            begin
                if (e.pings_left != '0)
                begin
                    s.entry.pings_left = e.pings_left - 1'b1;
                end
                if (s.entry.pings_left == '0)
                begin
                    s.verdict = V_TIMED;
                end
                else
                begin
                    s.entry.ping_cd = tbp;
                    s.verdict       = V_PING;
                end
            end
        end
        return s;
    endfunction

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [IDXW:0]     rd_idx_reg, rd_idx_next;
    logic              ex_vld_reg, ex_vld_next;
    logic [IDXW-1:0]   ex_idx_reg, ex_idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              held_vld_reg, held_vld_next;
    logic [SLOT_W-1:0] held_slot_reg, held_slot_next;
    verdict_t          held_verdict_reg, held_verdict_next;
    logic [IVL_W-1:0]  tbp_reg, tbp_next;
    logic [ATT_W-1:0]  pbp_reg, pbp_next;

    logic              out_vld_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    verdict_t          out_verdict_reg;
    logic              out_last_reg;

    logic              push_vld;
    logic [SLOT_W-1:0] push_slot;
    verdict_t          push_verdict;
    logic              push_last;
    logic              out_can;

    logic              ram_we;
    logic [IDXW-1:0]   ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [IDXW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    logic              ex_live;
    logic              report;
    logic              stall;
    step_t             st;
    logic [IDXW-1:0]   cmd_idx;
    logic [IDXW-1:0]   cmd_reg_idx;

    assign rd_entry    = entry_t'(ram_rdata);
    assign out_can     = !out_vld_reg || m_axis_tready;
    assign cfg_ready   = 1'b1;
    assign cmd_idx     = IDXW'(cmd.slot);
    assign cmd_reg_idx = IDXW'(cmd_reg.slot);

    crkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // tick step on the slot most recently read from the table
    always_comb
    begin
        st      = slot_step(rd_entry, tbp_reg);
        ex_live = ex_vld_reg && valid_reg[ex_idx_reg];
        report  = ex_live && (st.verdict != V_ACK) && (n_reg < CNT_W'(MAX_RESULTS));
        stall   = report && held_vld_reg && !out_can;
    end

    // sequencer: next state, table access and result transfers
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        valid_next        = valid_reg;
        rd_idx_next       = rd_idx_reg;
        ex_vld_next       = ex_vld_reg;
        ex_idx_next       = ex_idx_reg;
        n_next            = n_reg;
        held_vld_next     = held_vld_reg;
        held_slot_next    = held_slot_reg;
        held_verdict_next = held_verdict_reg;
        tbp_next          = tbp_reg;
        pbp_next          = pbp_reg;
        pop               = 1'b0;
        push_vld          = 1'b0;
        push_slot         = '0;
        push_verdict      = V_ACK;
        push_last         = 1'b1;
        ram_we            = 1'b0;
        ram_waddr         = cmd_idx;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = cmd_idx;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PING_INTERVAL:      tbp_next = cfg_data;
                CFG_PINGS_BEFORE_PURGE: pbp_next = cfg_data[ATT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        OP_TICK:
                        begin
                            rd_idx_next   = '0;
                            ex_vld_next   = 1'b0;
                            n_next        = '0;
                            held_vld_next = 1'b0;
                            state_next    = B_TICK;
                        end
                        OP_LOAD:
                        begin
                            if (cmd.in_range)
                            begin
                                ram_we               = 1'b1;
                                ram_wdata.cls        = cmd.conn_class;
                                ram_wdata.period     = cmd.retry_interval;
                                ram_wdata.retry_cd   = cmd.retry_interval;
                                ram_wdata.att_left   = cmd.attempts;
                                ram_wdata.ping_cd    = tbp_reg;
                                ram_wdata.pings_left = pbp_reg;
                                valid_next[cmd_idx]  = 1'b1;
                            end
                            state_next = B_ACK;
                        end
                        OP_SETC:
                        begin
                            if (cmd.in_range)
                            begin
                                ram_re     = 1'b1;
                                state_next = B_SETC;
                            end
                            else
                            begin
                                state_next = B_ACK;
                            end
                        end
                        default:
                        begin
                            if (cmd.in_range)
                            begin
                                valid_next[cmd_idx] = 1'b0;
                            end
                            state_next = B_ACK;
                        end
                    endcase
                end
            end
            B_SETC:
            begin
                // rewrite the entry with only the class changed
                ram_we        = 1'b1;
                ram_waddr     = cmd_reg_idx;
                ram_wdata     = rd_entry;
                ram_wdata.cls = cmd_reg.conn_class;
                state_next    = B_ACK;
            end
            B_ACK:
            begin
                if (out_can)
                begin
                    push_vld   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_TICK:
            begin
                if (!stall)
                begin
                    if (ex_live)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ex_idx_reg;
                        ram_wdata = st.entry;
                    end
                    // the newest report is held until the next proves it not last
                    if (report)
                    begin
                        if (held_vld_reg)
                        begin
                            push_vld     = 1'b1;
                            push_slot    = held_slot_reg;
                            push_verdict = held_verdict_reg;
                            push_last    = 1'b0;
                        end
                        held_vld_next     = 1'b1;
                        held_slot_next    = SLOT_W'(ex_idx_reg);
                        held_verdict_next = st.verdict;
                        n_next            = n_reg + 1'b1;
                    end
                    if (rd_idx_reg < (IDXW + 1)'(SLOTS))
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = rd_idx_reg[IDXW-1:0];
                        ex_vld_next = 1'b1;
                        ex_idx_next = rd_idx_reg[IDXW-1:0];
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        ex_vld_next = 1'b0;
                        if (!ex_vld_reg)
                        begin
                            state_next = B_FLUSH;
                        end
                    end
                end
            end
            B_FLUSH:
            begin
                if (out_can)
                begin
                    push_vld = 1'b1;
                    if (held_vld_reg)
                    begin
                        push_slot    = held_slot_reg;
                        push_verdict = held_verdict_reg;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            rd_idx_reg    <= '0;
            ex_vld_reg    <= 1'b0;
            n_reg         <= '0;
            held_vld_reg  <= 1'b0;
            tbp_reg       <= TBP_RESET;
            pbp_reg       <= PBP_RESET;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            rd_idx_reg   <= rd_idx_next;
            ex_vld_reg   <= ex_vld_next;
            n_reg        <= n_next;
            held_vld_reg <= held_vld_next;
            tbp_reg      <= tbp_next;
            pbp_reg      <= pbp_next;
            if (push_vld)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        ex_idx_reg       <= ex_idx_next;
        held_slot_reg    <= held_slot_next;
        held_verdict_reg <= held_verdict_next;
        if (push_vld)
        begin
            out_slot_reg    <= push_slot;
            out_verdict_reg <= push_verdict;
            out_last_reg    <= push_last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_verdict_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[hw/rtl/connection_retry_keepalive_timer_unit.sv]
// top level of the connection retry and keepalive timer
// depends on crkt_pkg, crkt_front and crkt_back
//
// Usage
//   s_axis carries commands: tuser selects tick, load, set class or remove,
//   tdata carries slot, class, retry interval and attempt count. m_axis
//   carries results (slot and verdict in tdata, tlast on the final result of
//   each command). cfg writes the ping interval (index 0) and
//   pings_before_purge (index 1); cfg_ready is always high.
// Sequence and throughput
//   load, remove: the table is written on acceptance, then the acknowledgement
//   is registered; set class first reads the slot, then writes it back.
//   a tick walks the slot memory one slot per cycle through its single read
//   port while the walk is not paused by an output stall; its last result is
//   held until the walk ends and then passed to the output register.
// Reset
//   rst_n clears all slot valid bits and the queue and loads the register
//   defaults; slot memory contents are not cleared, as only load validates.
// Stalls
//   a result waits in the output register while m_axis_tready is low; the
//   walk pauses when a second result is ready while the output register is
//   still occupied, and input stalls once the two-entry command queue fills.
module connection_retry_keepalive_timer_unit #(
    parameter int SLOTS = crkt_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: slot[4:0], conn_class[6:5], retry_interval[22:7], attempts[30:23]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [crkt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [crkt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // tdata: slot_out[4:0], verdict[7:5]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [crkt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crkt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crkt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import crkt_pkg::*;

    logic cmd_valid;
    logic pop;
    cmd_t cmd;

    crkt_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    crkt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .pop           (pop),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[hw/rtl/crkt_checker.sv]
// port-level checks for the connection retry and keepalive timer
// depends on crkt_pkg; bound to connection_retry_keepalive_timer_unit
module crkt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [crkt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import crkt_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // verdicts stay within the defined codes
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:5] == V_ACK || m_axis_tdata[7:5] == V_RETRY
            || m_axis_tdata[7:5] == V_TIMED || m_axis_tdata[7:5] == V_PING
            || m_axis_tdata[7:5] == V_PURGE))
        else $error("undefined verdict");

    // an acknowledgement is the only result of its command and names slot zero
    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7:5] == V_ACK
            |-> m_axis_tlast && m_axis_tdata[4:0] == '0)
        else $error("malformed acknowledgement");

    // a transfer not marked last is never an acknowledgement
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
            |-> m_axis_tdata[7:5] != V_ACK)
        else $error("report run broken by acknowledgement");

endmodule

bind connection_retry_keepalive_timer_unit crkt_checker u_crkt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[verif/tb_connection_retry_keepalive_timer_unit.sv]
// self-checking testbench for connection_retry_keepalive_timer_unit
// depends on crkt_pkg and the rtl of the block; predicts every result internally
module tb_connection_retry_keepalive_timer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import crkt_pkg::*;

    localparam int NSLOT      = 32;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        verdict_t          verdict;
        logic              last;
    } verdict_rec_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [IN_USER_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted table and registers
    logic [IVL_W-1:0]   tbp_reg;
    logic [ATT_W-1:0]   pbp_reg;
    logic               tbl_valid [NSLOT];
    logic [CLASS_W-1:0] tbl_class [NSLOT];
    logic [IVL_W-1:0]   tbl_period [NSLOT];
    logic [IVL_W-1:0]   tbl_retry_cd [NSLOT];
    logic [ATT_W-1:0]   tbl_att_left [NSLOT];
    logic [IVL_W-1:0]   tbl_ping_cd [NSLOT];
    logic [ATT_W-1:0]   tbl_pings_left [NSLOT];

    verdict_rec_t pending_verdicts[$];
    int errors;
    int burst_left;
    int idle_cycles;

    connection_retry_keepalive_timer_unit u_top (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // advance one valid slot by a tick
    function automatic verdict_t age_slot(input int i);
        if (tbl_class[i] == CLS_TIMED)
            return V_PURGE;
        if (tbl_class[i] == CLS_AWAIT)
        begin
            if (tbl_retry_cd[i] != 0) tbl_retry_cd[i]--;
            if (tbl_retry_cd[i] != 0) return V_ACK;
            if (tbl_att_left[i] != 0) tbl_att_left[i]--;
            if (tbl_att_left[i] == 0) return V_TIMED;
            tbl_period[i] = (tbl_period[i] >= 16'h8000) ? IVL_MAX : tbl_period[i] << 1;
            tbl_retry_cd[i] = tbl_period[i];
            return V_RETRY;
        end
        if (tbl_ping_cd[i] != 0) tbl_ping_cd[i]--;
        if (tbl_ping_cd[i] != 0) return V_ACK;
        if (tbl_pings_left[i] != 0) tbl_pings_left[i]--;
        if (tbl_pings_left[i] == 0) return V_TIMED;
        tbl_ping_cd[i] = tbp_reg;
        return V_PING;
    endfunction

    // work out the verdicts one accepted command causes
    function automatic void predict_verdicts(input op_t op, input int s,
                                             input logic [CLASS_W-1:0] cls,
                                             input logic [IVL_W-1:0] ivl,
                                             input logic [ATT_W-1:0] att);
        verdict_rec_t fired[$];
        verdict_rec_t r;
        verdict_t v;
        if (op == OP_TICK)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!tbl_valid[i]) continue;
                v = age_slot(i);
                if (v != V_ACK && fired.size() < MAX_RESULTS)
                begin
                    r.slot = i[SLOT_W-1:0];
                    r.verdict = v;
                    r.last = 1'b0;
                    fired.push_back(r);
                end
            end
        end
        else if (op == OP_LOAD)
        begin
            tbl_valid[s] = 1'b1;
            tbl_class[s] = cls;
            tbl_period[s] = ivl;
            tbl_retry_cd[s] = ivl;
            tbl_att_left[s] = att;
            tbl_ping_cd[s] = tbp_reg;
            tbl_pings_left[s] = pbp_reg;
        end
        else if (op == OP_SETC)
            tbl_class[s] = cls;
        else
            tbl_valid[s] = 1'b0;
        if (fired.size() == 0)
        begin
            r.slot = '0;
            r.verdict = V_ACK;
            r.last = 1'b1;
            fired.push_back(r);
        end
        else
        begin
            r = fired.pop_back();
            r.last = 1'b1;
            fired.push_back(r);
        end
        foreach (fired[k]) pending_verdicts.push_back(fired[k]);
    endfunction

    // send one command, in bursts with random gaps
    task automatic send_cmd(input op_t op, input int s, input logic [CLASS_W-1:0] cls,
                            input logic [IVL_W-1:0] ivl, input logic [ATT_W-1:0] att);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, att, ivl, cls, s[SLOT_W-1:0]};
        do @(posedge clk); while (!s_axis_tready);
        predict_verdicts(op, s, cls, ivl, att);
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (NSLOT + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_PING_INTERVAL) tbp_reg = val;
        else if (idx == CFG_PINGS_BEFORE_PURGE) pbp_reg = val[ATT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [IVL_W-1:0] tbp, input logic [ATT_W-1:0] pbp);
        drain();
        write_reg(CFG_PING_INTERVAL, tbp);
        write_reg(CFG_PINGS_BEFORE_PURGE, {8'd0, pbp});
    endtask

    // quiet tick, retry back-off to time-out, purge, class three, zero counts
    task automatic test_retry_and_purge();
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_LOAD, 0, CLS_AWAIT, 16'd1, 8'd2);
        send_cmd(OP_LOAD, 31, CLS_TIMED, 16'hFFFF, 8'hFF);
        send_cmd(OP_LOAD, 5, CLS_AWAIT, 16'd0, 8'd0);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_SETC, 0, 2'd3, 16'd0, 8'd0);
        send_cmd(OP_REMOVE, 31, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_REMOVE, 0, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_REMOVE, 5, 2'd0, 16'd0, 8'd0);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
    endtask

    // keepalive pings and time-out across register extremes
    task automatic test_keepalive();
        set_timing(16'd1, 8'd1);
        send_cmd(OP_LOAD, 3, 2'd1, 16'd9, 8'd9);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        set_timing(16'd2, 8'd255);
        send_cmd(OP_LOAD, 4, 2'd1, 16'd9, 8'd9);
        repeat (5) send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        set_timing(16'd0, 8'd0);
        send_cmd(OP_LOAD, 6, 2'd1, 16'd9, 8'd9);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
        set_timing(16'hFFFF, 8'd255);
        send_cmd(OP_LOAD, 7, 2'd1, 16'hFFFF, 8'd255);
        send_cmd(OP_TICK, 0, 2'd0, 16'd0, 8'd0);
    endtask

    // random commands over several register settings
    task automatic test_random();
        int pick;
        logic [IVL_W-1:0] ivl;
        logic [ATT_W-1:0] att;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_timing(16'd3, 8'd2);
                1: set_timing(16'd1, 8'd255);
                2: set_timing(16'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
                3: set_timing(16'd5, 8'd1);
                default: set_timing(TBP_RESET, PBP_RESET);
            endcase
            for (int n = 0; n < 50; n++)
            begin
                // one hold-off until the block has caught up
                if (phase == 2 && n == 25)
                    drain();
                pick = $urandom_range(0, 99);
                ivl = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                att = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                if (pick < 40)
                    send_cmd(OP_TICK, $urandom_range(0, 31), 2'($urandom), ivl, att);
                else if (pick < 70)
                    send_cmd(OP_LOAD, $urandom_range(0, 31), 2'($urandom), ivl, att);
                else if (pick < 85)
                    send_cmd(OP_SETC, $urandom_range(0, 31), 2'($urandom), ivl, att);
                else
                    send_cmd(OP_REMOVE, $urandom_range(0, 31), 2'($urandom), ivl, att);
            end
        end
    endtask

    // receiver stall pattern, changing mode at random
    initial
    begin
        int cyc;
        int mode;
        m_axis_tready = 1'b0;
        cyc = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (cyc % 64 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= (cyc % 4 != 0);
            endcase
            cyc++;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        verdict_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
                report($sformatf("unexpected result tdata=%h", m_axis_tdata));
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[4:0] !== want.slot)
                    report($sformatf("slot %0d, want %0d", m_axis_tdata[4:0], want.slot));
                if (m_axis_tdata[7:5] !== want.verdict)
                    report($sformatf("verdict %0d, want %0d", m_axis_tdata[7:5], want.verdict));
                if (m_axis_tlast !== want.last)
                    report($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL connection_retry_keepalive_timer_unit");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        errors = 0;
        burst_left = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tbp_reg = TBP_RESET;
        pbp_reg = PBP_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_class[i] = '0;
            tbl_period[i] = '0;
            tbl_retry_cd[i] = '0;
            tbl_att_left[i] = '0;
            tbl_ping_cd[i] = '0;
            tbl_pings_left[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_retry_and_purge();
        test_keepalive();
        test_random();
        drain();
        if (errors == 0)
            $display("PASS connection_retry_keepalive_timer_unit");
        else
            $display("FAIL connection_retry_keepalive_timer_unit");
        $finish;
    end
endmodule
